>>> hdl/assert_macros.svh
// Assertion helpers shared by the keypad scanner RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define KPS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> hdl/kps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types, constants and helpers of the 4x4 keypad scanner.
// ----------------------------------------------------------------------------
package kps_pkg;

  // Matrix geometry
  localparam int ROW_COUNT    = 4;
  localparam int COLUMN_COUNT = 4;

  // Field widths
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int IDX_W  = 2;
  localparam int CNT_W  = 16;
  localparam int CODE_W = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  // Register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_TABLE_LO = 2'd1;
  localparam logic [1:0] REG_TABLE_HI = 2'd2;

  // Debounce count after reset
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd50;

  // Scan phases
  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  // Configuration register contents
  typedef struct packed {
    logic [CNT_W-1:0]  debounce_ticks;
    logic [DATA_W-1:0] key_table_low;
    logic [DATA_W-1:0] key_table_high;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [COL_W-1:0]  column_drive;
    logic              scan_done;
    logic [CODE_W-1:0] key_code;
  } result_t;

  // Key code lookup: byte idx of the 16-byte table split over two words
  function automatic logic [CODE_W-1:0] table_byte(input logic [DATA_W-1:0] lo,
                                                   input logic [DATA_W-1:0] hi,
                                                   input logic [3:0]        idx);
    logic [DATA_W-1:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: CODE_W];
  endfunction

endpackage

>>> hdl/matrix_keypad_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_core
// 4x4 active-low keypad scanner with APB configuration.
// ----------------------------------------------------------------------------
// Each input beat is one scan tick carrying the row levels sampled with the
// previously driven column low (column 0 after reset). Every beat yields
// exactly one result beat: the column drive for the next sample, a pass-end
// flag and the key code of the finished pass (0 if no key). The block takes
// one beat per clock while not stalled; each beat passes the input register,
// then the scan logic into the output register. The input register stalls
// only when it holds a beat and the result register is full and not taken.
// Registers sit at byte addresses 0x00 (debounce ticks, 16 bit), 0x08 (key
// codes 0..7) and 0x10 (key codes 8..15); write them only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_keypad_scanner_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // tick input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kps_pkg::ROW_W-1:0]  in_row_levels,
  // result output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kps_pkg::COL_W-1:0]  out_column_drive,
  output logic                       out_scan_done,
  output logic [kps_pkg::CODE_W-1:0] out_key_code,
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kps_pkg::ADDR_W-1:0] paddr,
  input  logic [kps_pkg::DATA_W-1:0] pwdata,
  output logic [kps_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import kps_pkg::*;

  cfg_t              cfg;
  result_t           res;
  logic              in_vld_r;
  logic [ROW_W-1:0]  in_row_r;
  logic              out_vld_r;
  result_t           out_res_r;
  logic              s2_adv;
  logic              step_en;

  // Configuration registers
  kps_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: output register frees when empty or taken
  assign s2_adv   = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || s2_adv;
  assign step_en  = in_vld_r && s2_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_row_r <= in_row_levels;
    end
  end

  // Scan logic
  kps_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .row_levels (in_row_r),
    .cfg        (cfg),
    .res        (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_column_drive = out_res_r.column_drive;
  assign out_scan_done    = out_res_r.scan_done;
  assign out_key_code     = out_res_r.key_code;

  // Checks
  `KPS_ASSERT(a_stall_only_when_full, !in_ready |-> in_vld_r && out_vld_r && !out_ready, "input stalled with room in the pipe")

endmodule

>>> hdl/kps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_cfg_regs
// APB register file: debounce length and the two halves of the key table.
// ----------------------------------------------------------------------------
module kps_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kps_pkg::ADDR_W-1:0] paddr,
  input  logic [kps_pkg::DATA_W-1:0] pwdata,
  output logic [kps_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output kps_pkg::cfg_t             cfg
);
  import kps_pkg::*;

  logic [CNT_W-1:0]  debounce_r;
  logic [DATA_W-1:0] table_lo_r;
  logic [DATA_W-1:0] table_hi_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      table_lo_r <= '0;
      table_hi_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE: debounce_r <= pwdata[CNT_W-1:0];
        REG_TABLE_LO: table_lo_r <= pwdata;
        REG_TABLE_HI: table_hi_r <= pwdata;
        default: ;  // unmapped, ignored
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = {{(DATA_W-CNT_W){1'b0}}, debounce_r};
      REG_TABLE_LO: prdata = table_lo_r;
      REG_TABLE_HI: prdata = table_hi_r;
      default:      prdata = '0;
    endcase
  end

  assign cfg.debounce_ticks = debounce_r;
  assign cfg.key_table_low  = table_lo_r;
  assign cfg.key_table_high = table_hi_r;

endmodule

>>> hdl/kps_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_scan
// Scan state machine: column walk, debounce, key capture and release wait.
// One tick is processed per cycle in which step_en is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kps_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic [kps_pkg::ROW_W-1:0] row_levels,
  input  kps_pkg::cfg_t             cfg,
  output kps_pkg::result_t          res
);
  import kps_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic [IDX_W-1:0]   held_r, held_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CODE_W-1:0]  pass_key_r, pass_key_nxt;

  logic               found;
  logic [IDX_W-1:0]   low_row;
  logic               held_low;
  logic               leave_col;
  logic               last_col;
  logic               done;

  // Lowest-numbered low row
  always_comb begin
    found   = 1'b0;
    low_row = '0;
    for (int r = ROW_COUNT - 1; r >= 0; r--) begin
      if (!row_levels[r]) begin
        found   = 1'b1;
        low_row = IDX_W'(r);
      end
    end
  end

  assign held_low = !row_levels[held_r];
  assign last_col = (col_r >= IDX_W'(COLUMN_COUNT - 1));

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SCAN;
      col_r      <= '0;
      held_r     <= '0;
      cnt_r      <= '0;
      pass_key_r <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      col_r      <= col_nxt;
      held_r     <= held_nxt;
      cnt_r      <= cnt_nxt;
      pass_key_r <= pass_key_nxt;
    end
  end

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    cnt_nxt      = cnt_r;
    pass_key_nxt = pass_key_r;
    leave_col    = 1'b0;
    case (phase_r)
      PH_DEBOUNCE: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (held_low) begin
          pass_key_nxt = table_byte(cfg.key_table_low, cfg.key_table_high,
                                    {held_r, col_r});
          phase_nxt    = PH_RELEASE;
        end else begin
          leave_col = 1'b1;
        end
      end
      PH_RELEASE: begin
        if (!held_low) leave_col = 1'b1;
      end
      default: begin  // scanning; the spare code behaves the same
        if (found) begin
          held_nxt  = low_row;
          cnt_nxt   = cfg.debounce_ticks;
          phase_nxt = PH_DEBOUNCE;
        end else begin
          leave_col = 1'b1;
        end
      end
    endcase

    // Column advance, pass ends after the last column
    done    = leave_col && last_col;
    col_nxt = col_r;
    if (leave_col) begin
      phase_nxt = PH_SCAN;
      col_nxt   = last_col ? '0 : col_r + IDX_W'(1);
    end
    if (done) pass_key_nxt = '0;
  end

  // Result of this tick
  assign res.column_drive = ~(COL_W'(1) << col_nxt);
  assign res.scan_done    = done;
  assign res.key_code     = done ? pass_key_r : '0;

  // Checks
  `KPS_NEVER(a_code_only_on_done, res.key_code != '0 && !res.scan_done, "key code without pass end")
  `KPS_ASSERT(a_release_after_debounce, $rose(phase_r == PH_RELEASE) |-> $past(phase_r == PH_DEBOUNCE), "release wait entered without debounce")
  `KPS_ASSERT(a_hold_without_tick, !step_en |=> $stable(col_r) && $stable(pass_key_r), "scan state moved without a tick")

endmodule
